// ===== rtl/core/clli_pkg.sv =====
package clli_pkg;

    // Array geometry. Entry FREE_HEAD heads the free chain, entry LIST_HEAD
    // heads the data list, and a cursor of zero ends either chain.
    localparam int DEPTH     = 128;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int POS_W     = 7;
    localparam int LEN_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CMP_W     = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    typedef logic [PTR_W-1:0] t_ptr;

    localparam t_ptr FREE_HEAD = t_ptr'(0);
    localparam t_ptr LIST_HEAD = t_ptr'(DEPTH - 1);
    localparam t_ptr FREE_LAST = t_ptr'(DEPTH - 2);
    localparam t_ptr CNT_MAX   = t_ptr'(DEPTH - 2);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FRESH,
        S_FRESH_NEXT,
        S_WALK,
        S_LAST,
        S_LINK_FREE,
        S_LINK_PRED,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic wr_en;
        t_ptr wr_addr;
        t_ptr wr_data;
        t_ptr rd_addr;
    } t_link_req;

    typedef struct packed {
        logic              wr_en;
        t_ptr              wr_addr;
        logic [VAL_W-1:0]  wr_data;
        t_ptr              rd_addr;
    } t_elem_req;

endpackage

// ===== rtl/core/clli_if.sv =====
interface clli_cmd_if import clli_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface clli_rsp_if import clli_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  read_value;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output status, output read_value, output length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input length,
                    output ready);
endinterface

// ===== rtl/core/clli_ram.sv =====
module clli_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/clli_ctrl.sv =====
module clli_ctrl import clli_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    clli_cmd_if.sink                i_cmd,
    clli_rsp_if.source              o_rsp,
    output t_link_req               o_link_req,
    input  t_ptr                    i_link_rd_data,
    output t_elem_req               o_elem_req,
    input  logic [VAL_W-1:0]        i_elem_rd_data
);

    t_state               r_state, n_state;
    t_ptr                 r_init_idx;
    t_ptr                 r_count;
    t_cmd                 r_cmd;
    logic [POS_W-1:0]     r_pos;
    logic [VAL_W-1:0]     r_value;
    t_ptr                 r_fresh;
    t_ptr                 r_nf;
    t_ptr                 r_cur;
    logic [POS_W-1:0]     r_steps;
    t_status              r_status;
    logic [VAL_W-1:0]     r_rval;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [VAL_W-1:0]     r_out_rval;
    logic [LEN_W-1:0]     r_out_len;

    logic                 accept;
    logic                 out_free;
    t_cmd                 in_cmd;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 ins_ok;
    logic                 rd_ok;
    logic                 no_free;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign in_cmd      = t_cmd'(i_cmd.command);
    assign pos_ext     = CMP_W'(i_cmd.position);
    assign cnt_ext     = CMP_W'(r_count);
    assign ins_ok      = (i_cmd.position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign rd_ok       = (i_cmd.position != '0) && (pos_ext <= cnt_ext);
    assign no_free     = (i_link_rd_data == FREE_HEAD) || (i_link_rd_data == LIST_HEAD);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init_idx == LIST_HEAD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_READ) begin
                        n_state = rd_ok ? S_WALK : S_RESULT;
                    end else begin
                        n_state = ins_ok ? S_FRESH : S_RESULT;
                    end
                end
            end
            S_FRESH: begin
                n_state = no_free ? S_RESULT : S_FRESH_NEXT;
            end
            S_FRESH_NEXT: begin
                n_state = (r_pos == POS_W'(1)) ? S_LAST : S_WALK;
            end
            S_WALK: begin
                if (r_steps == POS_W'(1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = (r_cmd == CMD_READ) ? S_RESULT : S_LINK_FREE;
            end
            S_LINK_FREE: begin
                n_state = S_LINK_PRED;
            end
            S_LINK_PRED: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Memory requests. The element store shares the read address of the
    // cursor memory, so the value of the last entry walked arrives with its
    // cursor.
    always_comb begin
        o_link_req = '0;
        o_elem_req = '0;
        case (r_state)
            S_INIT: begin
                o_link_req.wr_en   = 1'b1;
                o_link_req.wr_addr = r_init_idx;
                o_link_req.wr_data = (r_init_idx >= FREE_LAST) ? FREE_HEAD
                                                                : r_init_idx + t_ptr'(1);
            end
            S_IDLE: begin
                o_link_req.rd_addr = (in_cmd == CMD_INSERT) ? FREE_HEAD : LIST_HEAD;
            end
            S_FRESH: begin
                o_link_req.rd_addr = i_link_rd_data;
            end
            S_FRESH_NEXT: begin
                o_link_req.rd_addr = LIST_HEAD;
            end
            S_WALK: begin
                o_link_req.rd_addr = i_link_rd_data;
            end
            S_LAST: begin
                if (r_cmd == CMD_INSERT) begin
                    o_link_req.wr_en   = 1'b1;
                    o_link_req.wr_addr = r_fresh;
                    o_link_req.wr_data = i_link_rd_data;
                    o_elem_req.wr_en   = 1'b1;
                    o_elem_req.wr_addr = r_fresh;
                    o_elem_req.wr_data = r_value;
                end
            end
            S_LINK_FREE: begin
                o_link_req.wr_en   = 1'b1;
                o_link_req.wr_addr = FREE_HEAD;
                o_link_req.wr_data = r_nf;
            end
            S_LINK_PRED: begin
                o_link_req.wr_en   = 1'b1;
                o_link_req.wr_addr = r_cur;
                o_link_req.wr_data = r_fresh;
            end
            default: begin
                o_link_req = '0;
            end
        endcase
        o_elem_req.rd_addr = o_link_req.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_init_idx <= r_init_idx + t_ptr'(1);
            end
            if (r_state == S_LINK_PRED) begin
                r_count <= r_count + t_ptr'(1);
            end
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd   <= in_cmd;
                r_pos   <= i_cmd.position;
                r_value <= i_cmd.value;
                r_cur   <= LIST_HEAD;
                r_steps <= i_cmd.position;
                r_status <= STAT_RANGE;
                r_rval   <= '0;
            end
            S_FRESH: begin
                r_fresh  <= i_link_rd_data;
                r_status <= STAT_FULL;
            end
            S_FRESH_NEXT: begin
                r_nf    <= i_link_rd_data;
                r_cur   <= LIST_HEAD;
                r_steps <= r_pos - POS_W'(1);
            end
            S_WALK: begin
                r_cur   <= i_link_rd_data;
                r_steps <= r_steps - POS_W'(1);
            end
            S_LAST: begin
                r_status <= STAT_OK;
                if (r_cmd == CMD_READ) begin
                    r_rval <= i_elem_rd_data;
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_RESULT && out_free) begin
            r_out_status <= r_status;
            r_out_rval   <= r_rval;
            r_out_len    <= LEN_W'(r_count);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rval;
    assign o_rsp.length     = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("element count exceeds capacity");

    a_walk_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (i_link_rd_data != FREE_HEAD))
        else $error("walk ran off the end of the list");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_PRED) |=> (r_count == $past(r_count) + t_ptr'(1)))
        else $error("count did not advance after a splice");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT && r_state != S_LAST && r_state != S_LINK_FREE
         && r_state != S_LINK_PRED) |-> !o_link_req.wr_en)
        else $error("cursor write outside init or splice");

endmodule

// ===== rtl/core/cursor_linked_list_insert.sv =====
// Cursor linked list with insert and read commands.
// Commands arrive as items on i_cmd (command, position, value); every
// command yields exactly one item on o_rsp (status, read_value, length).
// Both channels move an item when valid and ready are high at a clock edge.
// After reset the block writes every entry of the cursor memory, setting up
// the free chain and an empty data list; i_cmd.ready stays low during that pass.
// A rejected command goes straight to the result state. A read or an insert
// walks the cursor chain from the list head, one cursor memory read per
// step, so the walk grows with the position; an insert that finds no free
// entry goes to the result state before any walk.
// One command is worked on at a time; the next command is taken as soon as
// the result has moved into the output register, even while o_rsp is
// stalled. If the receiver keeps o_rsp.ready low, the following result waits
// in its final state and no further command is taken until the register
// frees up.
module cursor_linked_list_insert import clli_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clli_cmd_if.sink    i_cmd,
    clli_rsp_if.source  o_rsp
);

    // The list lives in two memories: the cursor array, which holds both
    // the free chain and the data list, and the element store, which is
    // only ever written at the fresh entry an insert takes.
    t_link_req          link_req;
    t_ptr               link_rd_data;
    t_elem_req          elem_req;
    logic [VAL_W-1:0]   elem_rd_data;

    clli_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .o_rsp          (o_rsp),
        .o_link_req     (link_req),
        .i_link_rd_data (link_rd_data),
        .o_elem_req     (elem_req),
        .i_elem_rd_data (elem_rd_data)
    );

    clli_ram #(
        .P_WIDTH (PTR_W),
        .P_DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_req.wr_en),
        .i_wr_addr (link_req.wr_addr),
        .i_wr_data (link_req.wr_data),
        .i_rd_addr (link_req.rd_addr),
        .o_rd_data (link_rd_data)
    );

    clli_ram #(
        .P_WIDTH (VAL_W),
        .P_DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (elem_req.wr_en),
        .i_wr_addr (elem_req.wr_addr),
        .i_wr_data (elem_req.wr_data),
        .i_rd_addr (elem_req.rd_addr),
        .o_rd_data (elem_rd_data)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench import clli_pkg::*; ();

    // One command item as the driver offers it, and one result item as the
    // list is expected to answer it.
    typedef struct {
        t_cmd                     command;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_list_cmd;

    typedef struct {
        t_status                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]         length;
    } t_list_rsp;

    // Random part of the stimulus; the directed part comes on top of it.
    localparam int RANDOM_ITEMS    = 1830;
    // Long receiver hold-off, so the block fills its result register and
    // then refuses further commands while the driver keeps offering.
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int HOLD_SPACING    = 1100;
    // The idle limit lies far beyond the slowest walk and the initial
    // clearing pass, so a stretch that long with no item moving on either
    // channel can only mean the block is stuck.
    localparam int IDLE_LIMIT      = 6000;
    localparam int DRAIN_CYCLES    = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    clli_cmd_if cmd_ch ();
    clli_rsp_if rsp_ch ();

    cursor_linked_list_insert DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    // Commands still to be offered, and results still owed by the block,
    // oldest first.
    t_list_cmd cmd_backlog [$];
    t_list_rsp awaited_rsps [$];

    // Shadow copy of the array: cursor chain, stored values and length.
    // Entry FREE_HEAD heads the free chain, entry LIST_HEAD the data list.
    t_ptr                    shadow_next [DEPTH];
    logic signed [VAL_W-1:0] shadow_elem [DEPTH];
    int unsigned             shadow_len;

    // Length the generator expects the list to reach, so that it can aim
    // positions at the valid range and just outside it.
    int planned_len = 0;

    int mismatch_count = 0;

    // Follow the data chain from the list head for a number of steps and
    // return the entry reached.
    function automatic t_ptr walk_to(int unsigned steps);
        t_ptr cur;
        cur = LIST_HEAD;
        for (int unsigned s = 0; s < steps; s++) begin
            cur = shadow_next[cur];
        end
        return cur;
    endfunction

    // Work out the result of one command and update the shadow list.
    // The range check of an insert comes before the check for a free
    // entry, so an insert past the end of a full list reports a range
    // error, while one at length+1 reports that no entry is free.
    function automatic t_list_rsp apply_list_cmd(t_list_cmd c);
        t_list_rsp r;
        t_ptr      fresh;
        t_ptr      pred;
        r.status     = STAT_OK;
        r.read_value = '0;
        if (c.command == CMD_INSERT) begin
            if (c.position < 1 || c.position > shadow_len + 1) begin
                r.status = STAT_RANGE;
            end else begin
                fresh = shadow_next[FREE_HEAD];
                if (fresh == FREE_HEAD || fresh == LIST_HEAD) begin
                    r.status = STAT_FULL;
                end else begin
                    // Unhook the fresh entry from the free chain and splice
                    // it in behind its predecessor.
                    pred = walk_to(int'(c.position) - 1);
                    shadow_next[FREE_HEAD] = shadow_next[fresh];
                    shadow_elem[fresh]     = c.value;
                    shadow_next[fresh]     = shadow_next[pred];
                    shadow_next[pred]      = fresh;
                    shadow_len++;
                end
            end
        end else begin
            if (c.position < 1 || c.position > shadow_len) begin
                r.status = STAT_RANGE;
            end else begin
                r.read_value = shadow_elem[walk_to(c.position)];
            end
        end
        r.length = LEN_W'(shadow_len);
        return r;
    endfunction

    // Queue one command and track the length it leads to.
    task automatic push_cmd(t_cmd kind, int pos, logic [VAL_W-1:0] val);
        t_list_cmd c;
        c.command  = kind;
        c.position = POS_W'(pos);
        c.value    = val;
        if (kind == CMD_INSERT && pos >= 1 && pos <= planned_len + 1
                && planned_len < int'(CNT_MAX)) begin
            planned_len++;
        end
        cmd_backlog.push_back(c);
    endtask

    // Stimulus and end of run.
    initial begin
        int                roll;
        int                top;
        int                pos;
        t_cmd              kind;
        logic [VAL_W-1:0]  pick_val;

        // The shadow list starts as the block does after its clearing pass:
        // every entry chained to the next, the free chain ending at the
        // entry before the list head, and the data list empty.
        for (int i = 0; i < DEPTH; i++) begin
            shadow_next[i] = t_ptr'(i + 1);
            shadow_elem[i] = '0;
        end
        shadow_next[FREE_LAST] = FREE_HEAD;
        shadow_next[LIST_HEAD] = FREE_HEAD;
        shadow_len = 0;

        // Directed part: empty-list reads, position zero, positions past the
        // end, inserts at head, middle and tail with extreme values, then
        // a read of every element, then reads and an insert past the end.
        push_cmd(CMD_READ,   1,   32'h1234_5678);
        push_cmd(CMD_READ,   0,   32'h0);
        push_cmd(CMD_INSERT, 0,   32'hDEAD_BEEF);
        push_cmd(CMD_INSERT, 2,   32'h0000_0001);
        push_cmd(CMD_INSERT, 127, 32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 1,   32'h8000_0000);
        push_cmd(CMD_INSERT, 2,   32'h7FFF_FFFF);
        push_cmd(CMD_INSERT, 1,   32'h0000_0000);
        push_cmd(CMD_INSERT, 2,   32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 5,   32'h5555_5555);
        push_cmd(CMD_INSERT, 3,   32'hAAAA_AAAA);
        for (int p = 1; p <= 6; p++) begin
            push_cmd(CMD_READ, p, 32'hFFFF_FFFF);
        end
        push_cmd(CMD_READ,   7,   32'h0);
        push_cmd(CMD_READ,   127, 32'h0);
        push_cmd(CMD_INSERT, 8,   32'h0F0F_0F0F);

        // Random part. Inserts are the minority, so the list fills up about
        // halfway through and the rest of the run exercises a full list:
        // inserts at length+1 then find no free entry. Most positions are
        // valid, with the head and the tail favored; the rest fall on zero
        // or past the valid range.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 11))
                0:       pick_val = 32'h8000_0000;
                1:       pick_val = 32'h7FFF_FFFF;
                2:       pick_val = 32'hFFFF_FFFF;
                3:       pick_val = 32'h0000_0000;
                default: pick_val = $urandom;
            endcase
            if (roll < 18) begin
                kind = CMD_INSERT;
                top  = planned_len + 1;
            end else begin
                kind = CMD_READ;
                top  = planned_len;
            end
            if (top >= 1 && $urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 3))
                    0:       pos = 1;
                    1:       pos = top;
                    default: pos = $urandom_range(1, top);
                endcase
            end else if (top + 1 <= 127 && $urandom_range(0, 1) == 1) begin
                pos = $urandom_range(top + 1, 127);
            end else begin
                pos = 0;
            end
            push_cmd(kind, pos, pick_val);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last command to be taken and its result to arrive,
        // then give the block time to show any stray result.
        while (cmd_backlog.size() != 0 || cmd_ch.valid) @(posedge i_clk);
        while (awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Driver. Items go out in bursts of random length separated by random
    // gaps, some of them zero. An offered item is held until the block takes
    // it; the result it should cause is worked out at that same edge.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.command  <= CMD_INSERT;
            cmd_ch.position <= '0;
            cmd_ch.value    <= '0;
        end else if (!(cmd_ch.valid && !cmd_ch.ready)) begin
            if (cmd_ch.valid) begin
                awaited_rsps.push_back(apply_list_cmd(cmd_backlog.pop_front()));
            end
            if (gap_left > 0 || cmd_backlog.size() == 0) begin
                cmd_ch.valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
            end else begin
                cmd_ch.valid    <= 1'b1;
                cmd_ch.command  <= cmd_backlog[0].command;
                cmd_ch.position <= cmd_backlog[0].position;
                cmd_ch.value    <= cmd_backlog[0].value;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
            end
        end
    end

    // Receiver. Ready follows a mode that changes at random intervals:
    // always ready, a coin toss, ready on a quarter of the ticks, or mostly ready. Twice
    // in the run it holds off completely for a long stretch, so the block
    // parks its result and stops taking commands while the driver offers.
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_tick      = 0;
    int hold_left    = 0;
    int rsp_seen     = 0;
    int next_hold_at = 200;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rx_tick++;
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen++;
            end
            if (rsp_seen >= next_hold_at) begin
                hold_left    = HOLD_OFF_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 400);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_ch.ready <= (rx_tick % 4 == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Monitor. Every result taken from the block is checked field by field
    // against the oldest result still owed.
    always @(posedge i_clk) begin
        t_list_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: status %0d read_value %0d length %0d",
                             rsp_ch.status, rsp_ch.read_value, rsp_ch.length);
                end
            end else begin
                want = awaited_rsps.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value
                        || rsp_ch.length !== want.length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch: expected status %0d read_value %0d",
                                 want.status, want.read_value,
                                 " length %0d, got status %0d read_value %0d length %0d",
                                 want.length, rsp_ch.status, rsp_ch.read_value,
                                 rsp_ch.length);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no item moves on either channel.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/clli_pkg.sv
rtl/core/clli_if.sv
rtl/core/clli_ram.sv
rtl/core/clli_ctrl.sv
rtl/core/cursor_linked_list_insert.sv
bench/testbench.sv
